@@ rtl/core/sms_pkg.sv @@
package sms_pkg;

	localparam int CAPACITY = 64;
	localparam int ELEM_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// field widths of the channels
	localparam int CMD_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 7;

	typedef logic [ELEM_W-1:0] elem_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2
	} cmd_t;

	// write strobes broadcast to every cell
	typedef struct packed {
		logic insert_en;
		logic remove_en;
	} cell_ctrl_t;

endpackage

@@ rtl/core/sms_cmd_if.sv @@
interface sms_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [sms_pkg::CMD_W-1:0]            command;
	logic signed [sms_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

@@ rtl/core/sms_res_if.sv @@
interface sms_res_if;
	logic                        valid;
	logic                        ready;
	logic                        ok;
	logic                        full_reject;
	logic [sms_pkg::COUNT_W-1:0] count;
	logic                        empty_res;

	modport source (output valid, output ok, output full_reject, output count,
		output empty_res, input ready);
	modport sink   (input valid, input ok, input full_reject, input count,
		input empty_res, output ready);
endinterface

@@ rtl/core/sms_cell.sv @@
module sms_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sms_pkg::elem_t      value,
	input  sms_pkg::cell_ctrl_t ctrl,
	input  logic                prior_free,
	output logic                any_free,
	output logic                match
);

	logic           valid_q;
	sms_pkg::elem_t stored_q;
	logic           claim;

	// first free cell along the chain takes an insert
	assign claim    = !valid_q && !prior_free;
	assign any_free = prior_free || !valid_q;
	assign match    = valid_q && (stored_q == value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert_en && claim) begin
			valid_q <= 1'b1;
		end else if (ctrl.remove_en && match) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert_en && claim) begin
			stored_q <= value;
		end
	end

endmodule

@@ rtl/core/set_membership_table.sv @@
// A command transaction accepted into cmd_q and value_q is executed against the
// cells into the result registers, waiting while a stalled result is still held.
// Throughput: one command per cycle unless results stall; each is resolved in one
// pass over the row of cells: all compare at once and the free-slot token ripples.
// Reset: arst_n clears every valid bit, the element count and both channel states
// at once; stored values are left as they are and need no clearing pass.
module set_membership_table (
	input  logic   clk,
	input  logic   arst_n,
	sms_cmd_if.sink   cmd,
	sms_res_if.source res
);

	logic                      busy_q;
	logic [sms_pkg::CMD_W-1:0] cmd_q;
	sms_pkg::elem_t            value_q;
	sms_pkg::cnt_t             cnt_q;
	logic                      out_valid_q;
	logic                      ok_q;
	logic                      reject_q;
	logic [sms_pkg::COUNT_W-1:0] count_q;
	logic                      empty_q;

	logic                        exec;
	logic                        hit;
	logic                        full;
	logic [sms_pkg::CAPACITY-1:0] match;
	logic [sms_pkg::CAPACITY:0]   free_chain;
	sms_pkg::cell_ctrl_t          ctrl;
	logic                         ok_d;
	logic                         reject_d;
	sms_pkg::cnt_t                cnt_d;

	assign exec      = busy_q && (!out_valid_q || res.ready);
	assign cmd.ready = !busy_q || exec;

	assign free_chain[0] = 1'b0;

	for (genvar i = 0; i < sms_pkg::CAPACITY; i++) begin : g_cell
		sms_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.value      (value_q),
			.ctrl       (ctrl),
			.prior_free (free_chain[i]),
			.any_free   (free_chain[i+1]),
			.match      (match[i])
		);
	end

	assign hit  = |match;
	assign full = !free_chain[sms_pkg::CAPACITY];

	always_comb begin
		ctrl     = '0;
		ok_d     = 1'b0;
		reject_d = 1'b0;
		cnt_d    = cnt_q;
		unique case (cmd_q)
			sms_pkg::CMD_INSERT: begin
				if (!hit) begin
					if (full) begin
						reject_d = 1'b1;
					end else begin
						ctrl.insert_en = exec;
						ok_d           = 1'b1;
						cnt_d          = cnt_q + sms_pkg::cnt_t'(1);
					end
				end
			end
			sms_pkg::CMD_REMOVE: begin
				ctrl.remove_en = exec;
				if (hit) begin
					ok_d  = 1'b1;
					cnt_d = cnt_q - sms_pkg::cnt_t'(1);
				end
			end
			sms_pkg::CMD_LOOKUP: begin
				ok_d = hit;
			end
			default: begin
				// unused code: set left untouched
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
				cnt_q       <= cnt_d;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q   <= cmd.command;
			value_q <= sms_pkg::ELEM_W'(cmd.value);
		end
		if (exec) begin
			ok_q     <= ok_d;
			reject_q <= reject_d;
			count_q  <= sms_pkg::COUNT_W'(cnt_d);
			empty_q  <= (cnt_d == '0);
		end
	end

	assign res.valid       = out_valid_q;
	assign res.ok          = ok_q;
	assign res.full_reject = reject_q;
	assign res.count       = count_q;
	assign res.empty_res   = empty_q;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	// code 3 has no member in cmd_t: the block must treat it as a no-op
	localparam logic [sms_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
	localparam int RANDOM_ITEMS = 1000;
	localparam int POOL_N       = sms_pkg::CAPACITY + sms_pkg::CAPACITY / 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	localparam logic signed [sms_pkg::VALUE_W-1:0] VAL_MIN =
		{1'b1, {(sms_pkg::VALUE_W-1){1'b0}}};
	localparam logic signed [sms_pkg::VALUE_W-1:0] VAL_MAX =
		{1'b0, {(sms_pkg::VALUE_W-1){1'b1}}};

	typedef struct {
		logic                        ok;
		logic                        full_reject;
		logic [sms_pkg::COUNT_W-1:0] count;
		logic                        empty_res;
	} set_result_t;

	class set_scoreboard;
		sms_pkg::elem_t held_value[sms_pkg::CAPACITY];
		bit             held[sms_pkg::CAPACITY];
		int             members;
		set_result_t    expected_q[$];
		int             errors;

		function new();
			members = 0;
			errors  = 0;
			foreach (held[i]) held[i] = 1'b0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// works out the set after an accepted command and queues its result
		function void note_command(logic [sms_pkg::CMD_W-1:0] code,
				logic signed [sms_pkg::VALUE_W-1:0] raw);
			sms_pkg::elem_t key;
			int             hit;
			int             free_slot;
			set_result_t    r;
			key       = sms_pkg::elem_t'(raw);
			hit       = -1;
			free_slot = -1;
			for (int i = 0; i < sms_pkg::CAPACITY; i++) begin
				if (held[i] && held_value[i] == key && hit < 0) hit = i;
				if (!held[i] && free_slot < 0) free_slot = i;
			end
			r.ok          = 1'b0;
			r.full_reject = 1'b0;
			case (code)
				sms_pkg::CMD_INSERT: begin
					if (hit < 0) begin
						if (free_slot < 0) begin
							r.full_reject = 1'b1;
						end else begin
							held_value[free_slot] = key;
							held[free_slot]       = 1'b1;
							members++;
							r.ok = 1'b1;
						end
					end
				end
				sms_pkg::CMD_REMOVE: begin
					if (hit >= 0) begin
						held[hit] = 1'b0;
						if (members > 0) members--;
						r.ok = 1'b1;
					end
				end
				sms_pkg::CMD_LOOKUP: r.ok = (hit >= 0);
				default: ;
			endcase
			r.count     = sms_pkg::COUNT_W'(members);
			r.empty_res = (members == 0);
			expected_q.push_back(r);
		endfunction

		function void check_result(logic ok, logic full_reject,
				logic [sms_pkg::COUNT_W-1:0] count, logic empty_res);
			set_result_t r;
			if (expected_q.size() == 0) begin
				$display("%0t: result transaction with nothing expected: %s",
					$time, $sformatf("ok=%b rej=%b count=%0d empty=%b",
					ok, full_reject, count, empty_res));
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (ok !== r.ok) begin
				$display("%0t: ok mismatch: expected %b actual %b", $time, r.ok, ok);
				errors++;
			end
			if (full_reject !== r.full_reject) begin
				$display("%0t: full_reject mismatch: expected %b actual %b",
					$time, r.full_reject, full_reject);
				errors++;
			end
			if (count !== r.count) begin
				$display("%0t: count mismatch: expected %0d actual %0d", $time, r.count, count);
				errors++;
			end
			if (empty_res !== r.empty_res) begin
				$display("%0t: empty_res mismatch: expected %b actual %b",
					$time, r.empty_res, empty_res);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sms_cmd_if cmd_if();
	sms_res_if res_if();

	set_membership_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	set_scoreboard sb = new();

	logic signed [sms_pkg::VALUE_W-1:0] value_pool[POOL_N];
	int burst_left;
	int items_sent;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// both channels are sampled here, on pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready)
				sb.note_command(cmd_if.command, cmd_if.value);
			if (res_if.valid && res_if.ready)
				sb.check_result(res_if.ok, res_if.full_reject, res_if.count, res_if.empty_res);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver back-pressure: the mode switches when its random run length runs out
	initial begin
		int stall_mode;
		int mode_left;
		int hold_left;
		int phase;
		stall_mode = 0;
		mode_left  = 0;
		hold_left  = 0;
		phase      = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(16, 96);
			end else begin
				mode_left--;
			end
			phase++;
			case (stall_mode)
				0: res_if.ready <= 1'b1;
				1: res_if.ready <= 1'($urandom_range(0, 1));
				2: res_if.ready <= (phase % 3 == 0);
				default: begin
					if (hold_left == 0) begin
						hold_left = $urandom_range(1, 10);
						res_if.ready <= 1'b0;
					end else begin
						hold_left--;
						res_if.ready <= (hold_left < 2);
					end
				end
			endcase
		end
	end

	// one command transaction; the sender drops valid only between bursts
	task automatic issue(input logic [sms_pkg::CMD_W-1:0] code,
			input logic signed [sms_pkg::VALUE_W-1:0] v);
		int gap;
		cmd_if.valid   <= 1'b1;
		cmd_if.command <= code;
		cmd_if.value   <= v;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cmd_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
	endtask

	function automatic logic signed [sms_pkg::VALUE_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 88)
			return value_pool[$urandom_range(0, POOL_N - 1)];
		return sms_pkg::VALUE_W'($urandom);
	endfunction

	function automatic logic [sms_pkg::CMD_W-1:0] pick_command(int insert_pct,
			int remove_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < insert_pct) return sms_pkg::CMD_INSERT;
		if (r < insert_pct + remove_pct) return sms_pkg::CMD_REMOVE;
		if (r < 96) return sms_pkg::CMD_LOOKUP;
		return CMD_NOP;
	endfunction

	initial begin
		int kind;
		int phase_len;
		int insert_pct;
		int remove_pct;
		cycles         = 0;
		items_sent     = 0;
		burst_left     = $urandom_range(1, 12);
		arst_n         <= 1'b0;
		cmd_if.valid   <= 1'b0;
		cmd_if.command <= sms_pkg::CMD_INSERT;
		cmd_if.value   <= '0;

		// pool larger than the table so insert-heavy phases run into a full table
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = '0;
		value_pool[3] = '1;
		for (int i = 4; i < POOL_N; i++) value_pool[i] = sms_pkg::VALUE_W'($urandom);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, duplicates, absent removes, unused code, back to empty
		issue(sms_pkg::CMD_LOOKUP, '0);
		issue(sms_pkg::CMD_REMOVE, 5);
		issue(sms_pkg::CMD_INSERT, '0);
		issue(sms_pkg::CMD_INSERT, VAL_MIN);
		issue(sms_pkg::CMD_INSERT, VAL_MAX);
		issue(sms_pkg::CMD_INSERT, '1);
		issue(sms_pkg::CMD_INSERT, '0);
		issue(sms_pkg::CMD_LOOKUP, VAL_MIN);
		issue(sms_pkg::CMD_LOOKUP, 1);
		issue(sms_pkg::CMD_REMOVE, VAL_MAX);
		issue(sms_pkg::CMD_REMOVE, VAL_MAX);
		issue(sms_pkg::CMD_LOOKUP, VAL_MAX);
		issue(CMD_NOP, '0);
		issue(CMD_NOP, '1);
		issue(sms_pkg::CMD_INSERT, 32'sh5555_5555);
		issue(sms_pkg::CMD_INSERT, 32'shAAAA_AAAA);
		issue(sms_pkg::CMD_LOOKUP, 32'shAAAA_AAAA);
		issue(sms_pkg::CMD_REMOVE, 32'sh5555_5555);
		issue(sms_pkg::CMD_REMOVE, 32'shAAAA_AAAA);
		issue(sms_pkg::CMD_REMOVE, '0);
		issue(sms_pkg::CMD_REMOVE, VAL_MIN);
		issue(sms_pkg::CMD_REMOVE, '1);
		issue(sms_pkg::CMD_LOOKUP, '1);
		issue(CMD_NOP, VAL_MIN);

		// random: phases that fill towards full, drain towards empty, or mix
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			kind      = $urandom_range(0, 2);
			phase_len = $urandom_range(30, 150);
			case (kind)
				0: begin insert_pct = 65; remove_pct = 12; end
				1: begin insert_pct = 10; remove_pct = 68; end
				default: begin insert_pct = 38; remove_pct = 30; end
			endcase
			repeat (phase_len) issue(pick_command(insert_pct, remove_pct), pick_value());
		end

		cmd_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
